// ===== rtl/nps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nps_pkg
// Shared constants and field widths for the nearest point search block.
// ----------------------------------------------------------------------------
package nps_pkg;

   localparam int MAX_POINTS_DEF  = 1024;
   localparam int COORD_BITS_DEF  = 16;
   localparam int COORD_MAX_BITS  = 24;

   localparam int INDEX_BITS      = 10;
   localparam int COORD_IN_BITS   = 16;
   localparam int DIST_OUT_BITS   = 34;
   localparam int COUNT_BITS      = 11;

   localparam int REQ_DATA_BITS   = 64;
   localparam int RSP_DATA_BITS   = 48;

   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic FUNC_WRITE    = 1'b0;
   localparam logic FUNC_QUERY    = 1'b1;

   // Register select: bit 2 of the byte address
   localparam logic REG_POINT_COUNT = 1'b0;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 11'd1;

endpackage : nps_pkg
`default_nettype wire

// ===== rtl/nps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nps_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module nps_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : nps_ram
`default_nettype wire

// ===== rtl/nps_sq_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nps_sq_unit
// Shared squared-difference unit: registers (a - b)^2 for signed coordinates.
// ----------------------------------------------------------------------------
module nps_sq_unit #(
   parameter int COORD_BITS = 16
) (
   input  wire                       clock,
   input  wire                       en,
   input  wire [COORD_BITS-1:0]      coord_a,
   input  wire [COORD_BITS-1:0]      coord_b,
   output logic [2*COORD_BITS-1:0]   sq_ff
);

   logic signed [COORD_BITS:0] diff;
   logic signed [COORD_BITS:0] neg_diff;
   logic [COORD_BITS-1:0]      mag;
   logic [2*COORD_BITS-1:0]    sq_in;

   assign diff     = $signed({coord_a[COORD_BITS-1], coord_a})
                   - $signed({coord_b[COORD_BITS-1], coord_b});
   assign neg_diff = -diff;
   assign mag      = diff[COORD_BITS] ? neg_diff[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
   assign sq_in    = (2*COORD_BITS)'(mag) * (2*COORD_BITS)'(mag);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
      end
   end

endmodule : nps_sq_unit
`default_nettype wire

// ===== rtl/nps_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nps_csr
// APB register file holding the point count searched by each query.
// ----------------------------------------------------------------------------
module nps_csr
   import nps_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_psel,
   input  wire                       csr_penable,
   input  wire                       csr_pwrite,
   input  wire [CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire [CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready,
   output logic [COUNT_BITS-1:0]     point_count
);

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  sel_count;

   assign csr_pready  = 1'b1;
   assign sel_count   = (csr_paddr[2] == REG_POINT_COUNT);
   assign point_count = count_ff;

   always_comb begin
      count_in = count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && sel_count) begin
         count_in = csr_pwdata[COUNT_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (sel_count) begin
         csr_prdata = CSR_DATA_BITS'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule : nps_csr
`default_nettype wire

// ===== rtl/nearest_point_search_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Write transaction: accepted in IDLE and stored, no response; one per cycle while in IDLE.
// Query transaction: rsp_tvalid rises once the search over n entries ends, n = point_count
//   clamped to 1..MAX_POINTS; each entry costs one squarer pass per axis plus a sum step.
// One query in flight; req_tready is high only in IDLE, so the next transaction is taken
//   once the result is loaded into the output register, later while a result waits there.
// Synchronous active-high reset clears control state and sets point_count to 1.
// ----------------------------------------------------------------------------
// nearest_point_search_top
// Brute-force nearest neighbor search over a table of signed 3-D points.
// ----------------------------------------------------------------------------
module nearest_point_search_top
   import nps_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   // [9:0] write_index, [25:10] coord_x, [41:26] coord_y, [57:42] coord_z, [63:58] zero
   input  wire [REQ_DATA_BITS-1:0]   req_tdata,
   // [0] func
   input  wire                       req_tuser,
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   // [9:0] nearest_index, [43:10] nearest_distance, [47:44] zero
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input  wire                       csr_psel,
   input  wire                       csr_penable,
   input  wire                       csr_pwrite,
   input  wire [CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire [CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready
);

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int PT_W   = 3 * COORD_BITS;
   localparam int DIST_W = 2 * COORD_BITS + 2;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_SQ    = 3'd2;
   localparam logic [2:0] S_SUM   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   logic [2:0]             state_ff, state_in;
   logic [1:0]             axis_ff, axis_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       last_ff, last_in;
   logic                   first_ff, first_in;
   logic [PT_W-1:0]        query_ff, query_in;
   logic [DIST_W-1:0]      acc_ff, acc_in;
   logic [DIST_W-1:0]      best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [COUNT_BITS-1:0]  point_count;
   logic [31:0]            count_wide;
   logic [31:0]            n_m1;
   logic [31:0]            wr_idx_wide;
   logic                   wr_idx_ok;
   logic [COORD_MAX_BITS-1:0] cx_wide, cy_wide, cz_wide;
   logic [PT_W-1:0]        req_point;

   logic                   req_acc;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [PT_W-1:0]        ram_rd_data;

   logic [COORD_BITS-1:0]  sq_a, sq_b;
   logic                   sq_en;
   logic [2*COORD_BITS-1:0] sq_ff;
   logic [DIST_W-1:0]      total;
   logic                   out_free;

   nps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .point_count (point_count)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   assign cx_wide   = COORD_MAX_BITS'(req_tdata[25:10]);
   assign cy_wide   = COORD_MAX_BITS'(req_tdata[41:26]);
   assign cz_wide   = COORD_MAX_BITS'(req_tdata[57:42]);
   assign req_point = {cz_wide[COORD_BITS-1:0], cy_wide[COORD_BITS-1:0],
                       cx_wide[COORD_BITS-1:0]};

   assign wr_idx_wide = 32'(req_tdata[INDEX_BITS-1:0]);
   assign wr_idx_ok   = (wr_idx_wide < 32'(MAX_POINTS));
   assign ram_wr_en   = req_acc && (req_tuser == FUNC_WRITE) && wr_idx_ok;

   assign count_wide = 32'(point_count);
   always_comb begin
      if (count_wide == 32'd0) begin
         n_m1 = 32'd0;
      end else if (count_wide > 32'(MAX_POINTS)) begin
         n_m1 = 32'(MAX_POINTS) - 32'd1;
      end else begin
         n_m1 = count_wide - 32'd1;
      end
   end

   nps_ram #(
      .WIDTH (PT_W),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_wide[IDX_W-1:0]),
      .wr_data (req_point),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      case (axis_ff)
         AXIS_Y: begin
            sq_a = ram_rd_data[2*COORD_BITS-1:COORD_BITS];
            sq_b = query_ff[2*COORD_BITS-1:COORD_BITS];
         end
         AXIS_Z: begin
            sq_a = ram_rd_data[3*COORD_BITS-1:2*COORD_BITS];
            sq_b = query_ff[3*COORD_BITS-1:2*COORD_BITS];
         end
         default: begin
            sq_a = ram_rd_data[COORD_BITS-1:0];
            sq_b = query_ff[COORD_BITS-1:0];
         end
      endcase
   end

   assign sq_en = (state_ff == S_SQ);

   nps_sq_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_sq (
      .clock   (clock),
      .en      (sq_en),
      .coord_a (sq_a),
      .coord_b (sq_b),
      .sq_ff   (sq_ff)
   );

   assign total    = acc_ff + DIST_W'(sq_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      first_in     = first_ff;
      query_in     = query_ff;
      acc_in       = acc_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_tuser == FUNC_QUERY)) begin
               state_in = S_FETCH;
               idx_in   = '0;
               last_in  = n_m1[IDX_W-1:0];
               first_in = 1'b1;
               query_in = req_point;
            end
         end
         S_FETCH: begin
            ram_rd_en = 1'b1;
            axis_in   = AXIS_X;
            state_in  = S_SQ;
         end
         S_SQ: begin
            if (axis_ff == AXIS_X) begin
               acc_in = '0;
            end else begin
               acc_in = total;
            end
            if (axis_ff == AXIS_Z) begin
               state_in = S_SUM;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         S_SUM: begin
            if (first_ff || (total < best_dist_ff)) begin
               best_dist_in = total;
               best_idx_in  = idx_ff;
            end
            first_in = 1'b0;
            axis_in  = AXIS_X;
            if (idx_ff == last_ff) begin
               state_in = S_DONE;
            end else begin
               idx_in      = idx_ff + IDX_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + IDX_W'(1);
               state_in    = S_SQ;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_BITS'({DIST_OUT_BITS'(best_dist_ff),
                                              INDEX_BITS'(best_idx_ff)});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= AXIS_X;
         idx_ff       <= '0;
         last_ff      <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff     <= query_in;
      acc_ff       <= acc_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_tuser == FUNC_QUERY)) |=> (state_ff == S_FETCH))
      else $error("query transaction did not start a search");

   a_best_monotonic: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SUM) && !first_ff) |=> (best_dist_ff <= $past(best_dist_ff)))
      else $error("best distance grew during a search");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (idx_ff <= last_ff))
      else $error("search index passed the last entry");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside the done step");
`endif

endmodule : nearest_point_search_top
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point search testbench
// Fills the whole point table, then streams point writes and nearest-point
// queries under several point_count settings (0, 1, 1024 and 2047 among
// them). Each query result is checked against an in-bench search over a
// shadow copy of the table. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench
   import nps_pkg::*;
();

   localparam int QUIET_LIMIT = 25000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 64;
   localparam int PHASES = 12;
   localparam logic [CSR_ADDR_BITS-1:0] POINT_COUNT_ADDR = {REG_POINT_COUNT, 2'b00};

   typedef struct {
      shortint x;
      shortint y;
      shortint z;
   } point_type;

   typedef struct {
      logic                  func;
      logic [INDEX_BITS-1:0] write_index;
      point_type             pt;
      bit                    drain_first;
   } point_request_type;

   typedef struct {
      logic [INDEX_BITS-1:0]    index;
      logic [DIST_OUT_BITS-1:0] distance;
   } nearest_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     req_tuser = FUNC_WRITE;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   point_request_type point_requests[$];
   nearest_type       nearest_due[$];
   point_type         point_table[MAX_POINTS_DEF];
   point_type         plan_table[MAX_POINTS_DEF];
   logic [COUNT_BITS-1:0] count_setting = COUNT_RESET;

   bit       sender_gaps = 1'b1;
   bit       receiver_gaps = 1'b1;
   bit       req_taken = 1'b0;
   int       send_hold = 0;
   int       rsp_hold = 0;
   int       quiet_cycles = 0;
   int       mismatches = 0;
   int       writes_seen = 0;
   int       queries_seen = 0;
   int       results_checked = 0;
   int       settings_applied = 0;
   point_request_type next_item;
   point_type   arrived;
   nearest_type want;

   nearest_point_search_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned effective_span(logic [COUNT_BITS-1:0] count);
      if (count == 0) return 1;
      if (count > MAX_POINTS_DEF) return MAX_POINTS_DEF;
      return count;
   endfunction

   function automatic logic [DIST_OUT_BITS-1:0] squared_distance(point_type a, point_type b);
      longint dx, dy, dz;
      dx = longint'(a.x) - longint'(b.x);
      dy = longint'(a.y) - longint'(b.y);
      dz = longint'(a.z) - longint'(b.z);
      return DIST_OUT_BITS'(dx * dx + dy * dy + dz * dz);
   endfunction

   function automatic nearest_type find_nearest(point_type q);
      nearest_type best;
      logic [DIST_OUT_BITS-1:0] d;
      int unsigned span;
      span = effective_span(count_setting);
      best.index = '0;
      best.distance = squared_distance(point_table[0], q);
      for (int unsigned i = 1; i < span; i++) begin
         d = squared_distance(point_table[i], q);
         if (d < best.distance) begin
            best.distance = d;
            best.index = INDEX_BITS'(i);
         end
      end
      return best;
   endfunction

   function automatic point_type unpack_point(logic [REQ_DATA_BITS-1:0] word);
      point_type p;
      p.x = shortint'(word[25:10]);
      p.y = shortint'(word[41:26]);
      p.z = shortint'(word[57:42]);
      return p;
   endfunction

   function automatic point_type make_point(int x, int y, int z);
      point_type p;
      p.x = shortint'(x);
      p.y = shortint'(y);
      p.z = shortint'(z);
      return p;
   endfunction

   function automatic shortint pick_coord();
      case ($urandom_range(0, 9))
         0: return shortint'(16'h8000);
         1: return shortint'(16'h7FFF);
         2: return shortint'(0);
         3: return shortint'(-1);
         default: return shortint'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic point_type random_point();
      point_type p;
      p.x = pick_coord();
      p.y = pick_coord();
      p.z = pick_coord();
      return p;
   endfunction

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 4);
      return $urandom_range(12, 60);
   endfunction

   task automatic queue_item(logic func, int unsigned index, point_type p, bit drain);
      point_request_type item;
      item.func = func;
      item.write_index = INDEX_BITS'(index);
      item.pt = p;
      item.drain_first = drain;
      if (func == FUNC_WRITE) plan_table[index] = p;
      point_requests.push_back(item);
   endtask

   task automatic queue_random_item(int unsigned span);
      point_type p;
      int unsigned src, idx;
      int delta;
      bit drain;
      src = $urandom_range(0, span - 1);
      drain = ($urandom_range(0, 32) == 0);
      if ($urandom_range(0, 99) < 45) begin
         if ($urandom_range(0, 4) != 0) idx = $urandom_range(0, span - 1);
         else idx = $urandom_range(0, MAX_POINTS_DEF - 1);
         if ($urandom_range(0, 2) == 0) p = plan_table[src];
         else p = random_point();
         queue_item(FUNC_WRITE, idx, p, drain);
      end else begin
         case ($urandom_range(0, 5))
            0, 1: p = plan_table[src];
            2: begin
               p = plan_table[src];
               delta = $urandom_range(0, 6);
               p.x = shortint'(p.x + delta - 3);
               delta = $urandom_range(0, 6);
               p.z = shortint'(p.z + delta - 3);
            end
            default: p = random_point();
         endcase
         queue_item(FUNC_QUERY, $urandom_range(0, MAX_POINTS_DEF - 1), p, drain);
      end
   endtask

   task automatic wait_until_drained();
      while (point_requests.size() != 0 || req_tvalid || nearest_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_point_count(logic [COUNT_BITS-1:0] value);
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= POINT_COUNT_ADDR;
      csr_pwdata <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      count_setting = value;
      settings_applied++;
   endtask

   // Sender: hold the current transaction until taken, then idle or present the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_hold > 0) begin
            send_hold--;
            req_tvalid <= 1'b0;
         end else if (point_requests.size() != 0 &&
                      !(point_requests[0].drain_first && nearest_due.size() != 0)) begin
            next_item = point_requests.pop_front();
            req_tdata <= {6'b0, next_item.pt.z, next_item.pt.y, next_item.pt.x,
                          next_item.write_index};
            req_tuser <= next_item.func;
            req_tvalid <= 1'b1;
            if (sender_gaps) send_hold = idle_length();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         if (receiver_gaps) rsp_hold = idle_length();
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (req_tvalid && req_tready) begin
            arrived = unpack_point(req_tdata);
            if (req_tuser == FUNC_WRITE) begin
               point_table[req_tdata[INDEX_BITS-1:0]] = arrived;
               writes_seen++;
            end else begin
               nearest_due.push_back(find_nearest(arrived));
               queries_seen++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (nearest_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with no query pending: index %0d distance %0d",
                           $realtime, rsp_tdata[9:0], rsp_tdata[43:10]);
            end else begin
               want = nearest_due.pop_front();
               if (rsp_tdata[9:0] !== want.index || rsp_tdata[43:10] !== want.distance) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: nearest mismatch: index %0d (exp %0d) distance %0d (exp %0d)",
                              $realtime, rsp_tdata[9:0], want.index,
                              rsp_tdata[43:10], want.distance);
               end
            end
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin
      int unsigned phase_count [PHASES];
      int unsigned span, items;
      phase_count = '{1, 2, 3, 6, 16, 40, 1024, 0, 255, 2, 1023, 12};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 1; i < MAX_POINTS_DEF; i++) queue_item(FUNC_WRITE, i, random_point(), 1'b0);
      queue_item(FUNC_WRITE, 0, make_point(-32768, -32768, -32768), 1'b0);
      queue_item(FUNC_WRITE, 1023, make_point(32767, 32767, 32767), 1'b0);
      queue_item(FUNC_QUERY, 1023, make_point(32767, 32767, 32767), 1'b0);
      queue_item(FUNC_QUERY, 0, make_point(-32768, -32768, -32768), 1'b0);
      queue_item(FUNC_QUERY, 5, make_point(0, 0, 0), 1'b0);

      set_point_count(COUNT_BITS'(0));
      queue_item(FUNC_QUERY, 0, make_point(1, 2, 3), 1'b0);

      set_point_count(COUNT_BITS'(4));
      queue_item(FUNC_WRITE, 1, make_point(32767, -32768, 0), 1'b0);
      queue_item(FUNC_WRITE, 2, make_point(10, 0, 0), 1'b0);
      queue_item(FUNC_WRITE, 3, make_point(-10, 0, 0), 1'b0);
      queue_item(FUNC_QUERY, 0, make_point(0, 0, 0), 1'b0);
      queue_item(FUNC_QUERY, 0, make_point(32767, -32768, 1), 1'b0);
      queue_item(FUNC_WRITE, 3, make_point(10, 0, 0), 1'b0);
      queue_item(FUNC_QUERY, 0, make_point(10, 0, 0), 1'b1);

      set_point_count(COUNT_BITS'(2047));
      queue_item(FUNC_QUERY, 1023, make_point(32767, 32767, 32767), 1'b0);
      queue_item(FUNC_QUERY, 0, make_point(-32768, 32767, -32768), 1'b0);

      set_point_count(COUNT_BITS'(1024));
      queue_item(FUNC_QUERY, 0, make_point(0, 0, 0), 1'b0);
      queue_item(FUNC_QUERY, 0, random_point(), 1'b0);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (phase_count[ph] == 0) phase_count[ph] = $urandom_range(41, 300);
         set_point_count(COUNT_BITS'(phase_count[ph]));
         if (ph == 1) begin
            sender_gaps = 1'b0;
            receiver_gaps = 1'b0;
         end else if (ph == 4) begin
            sender_gaps = 1'b1;
            receiver_gaps = 1'b1;
         end else begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            receiver_gaps = ($urandom_range(0, 3) != 0);
         end
         span = effective_span(COUNT_BITS'(phase_count[ph]));
         items = (span >= 512) ? 10 : 56;
         for (int k = 0; k < items; k++) queue_random_item(span);
      end

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d point writes and %0d nearest-point queries (%0d results checked)",
               writes_seen, queries_seen, results_checked);
      $display("over %0d point_count settings, %0d mismatches", settings_applied, mismatches);
      if (mismatches == 0 && nearest_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/nps_sq_unit.sv
rtl/nps_csr.sv
rtl/nearest_point_search_top.sv
tb/testbench.sv
